// ===== hdl/qwmi_pkg.sv =====
package qwmi_pkg;

    localparam int DEFAULT_CAPACITY = 256;
    localparam int VALUE_W = 32;
    localparam int OCC_W = 9;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_POP    = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [OCC_W-1:0] occ_t;

    typedef struct packed {
        logic [1:0] command;
        value_t     value;
    } request_t;

    typedef struct packed {
        value_t     popped_value;
        logic [1:0] status;
        occ_t       occupancy;
    } result_t;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_POP    = 2'd1,
        OP_INSERT = 2'd2
    } cell_kind_t;

    typedef struct packed {
        cell_kind_t kind;
        value_t     value;
    } cell_op_t;

endpackage

// ===== hdl/queue_with_middle_insertion.sv =====
// Queue of signed 32-bit values with append at the back, insertion in the
// middle (right after the first ceil(n/2) entries) and pop from the front.
// A request is taken at a rising edge where start is high and busy is low.
// The request carries a command and a value; the value is ignored for a pop.
// Exactly one result follows each request: done is high for one cycle, the
// cycle after the request is taken, with the popped value, a status code and
// the occupancy after the command. Busy stays low, so a request can be taken
// in every cycle.
// The entries sit in a row of cells, one entry per cell, in queue order.
// A pop shifts the whole row one cell toward the front; an insertion writes
// one cell and shifts the cells behind it one place toward the back.
// A pop from an empty queue and a push into a full queue leave the queue
// unchanged and are reported in the status.
// Reset empties the queue; no result is pending after reset.
// The receiver cannot stall: each result must be taken in its done cycle.
module queue_with_middle_insertion #(
    parameter int CAPACITY = qwmi_pkg::DEFAULT_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  qwmi_pkg::request_t request,
    output logic               done,
    output qwmi_pkg::result_t  result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               accept;
    qwmi_pkg::cell_op_t op;
    logic [IDX_W-1:0]   pos;
    qwmi_pkg::value_t   cell_data [CAPACITY];

    assign busy = 1'b0;
    assign accept = start && !busy;

    qwmi_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .request   (request),
        .head_data (cell_data[0]),
        .op        (op),
        .pos       (pos),
        .done      (done),
        .result    (result)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        qwmi_pkg::value_t left_data;
        qwmi_pkg::value_t right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[i];
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        qwmi_cell #(
            .IDX_W (IDX_W),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .op         (op),
            .pos        (pos),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("Result strobe missing after an accepted request.");

    a_done_only_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept))
        else $error("Result strobe without an accepted request.");

    a_full_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == qwmi_pkg::ST_FULL)
            |-> (result.occupancy == qwmi_pkg::occ_t'(CAPACITY)))
        else $error("Push rejected although the queue was not full.");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status == qwmi_pkg::ST_EMPTY)
            |-> (result.occupancy == '0 && result.popped_value == '0))
        else $error("Failed pop reported a value or a nonzero occupancy.");

endmodule

// ===== hdl/qwmi_cell.sv =====
module qwmi_cell #(
    parameter int IDX_W = 8,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  qwmi_pkg::cell_op_t op,
    input  logic [IDX_W-1:0]   pos,
    input  qwmi_pkg::value_t   left_data,
    input  qwmi_pkg::value_t   right_data,
    output qwmi_pkg::value_t   data
);

    localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

    qwmi_pkg::value_t data_reg;
    qwmi_pkg::value_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (op.kind)
            qwmi_pkg::OP_POP:
            begin
                data_next = right_data;
            end
            qwmi_pkg::OP_INSERT:
            begin
                if (MY_INDEX == pos)
                begin
                    data_next = op.value;
                end
                else if (MY_INDEX > pos)
                begin
                    data_next = left_data;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== hdl/qwmi_ctrl.sv =====
module qwmi_ctrl #(
    parameter int CAPACITY = qwmi_pkg::DEFAULT_CAPACITY,
    parameter int IDX_W = $clog2(CAPACITY),
    parameter int CNT_W = $clog2(CAPACITY + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  qwmi_pkg::request_t  request,
    input  qwmi_pkg::value_t    head_data,
    output qwmi_pkg::cell_op_t  op,
    output logic [IDX_W-1:0]    pos,
    output logic                done,
    output qwmi_pkg::result_t   result
);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    qwmi_pkg::result_t result_reg;
    qwmi_pkg::result_t result_next;
    logic [CNT_W-1:0]  half_up;
    logic              full;
    logic              empty;

    assign full = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign half_up = CNT_W'((count_reg + CNT_W'(1)) >> 1);

    always_comb
    begin
        count_next = count_reg;
        op.kind = qwmi_pkg::OP_NONE;
        op.value = request.value;
        pos = IDX_W'(count_reg);
        result_next.popped_value = '0;
        result_next.status = qwmi_pkg::ST_OK;
        if (accept)
        begin
            case (request.command)
                qwmi_pkg::CMD_APPEND, qwmi_pkg::CMD_INSERT:
                begin
                    if (full)
                    begin
                        result_next.status = qwmi_pkg::ST_FULL;
                    end
                    else
                    begin
                        op.kind = qwmi_pkg::OP_INSERT;
                        if (request.command == qwmi_pkg::CMD_INSERT)
                        begin
                            pos = IDX_W'(half_up);
                        end
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                qwmi_pkg::CMD_POP:
                begin
                    if (empty)
                    begin
                        result_next.status = qwmi_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        op.kind = qwmi_pkg::OP_POP;
                        result_next.popped_value = head_data;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
        result_next.occupancy = qwmi_pkg::occ_t'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

    localparam int CAPACITY = qwmi_pkg::DEFAULT_CAPACITY;
    localparam int TOTAL_ITEMS = 1620;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam qwmi_pkg::value_t VALUE_MIN = {1'b1, {(qwmi_pkg::VALUE_W - 1){1'b0}}};
    localparam qwmi_pkg::value_t VALUE_MAX = {1'b0, {(qwmi_pkg::VALUE_W - 1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    qwmi_pkg::request_t request = '0;
    qwmi_pkg::result_t result;

    queue_with_middle_insertion u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    qwmi_pkg::request_t pending_requests[$];
    qwmi_pkg::result_t expected_results[$];
    qwmi_pkg::value_t queue_contents[$];

    int error_count = 0;
    int planned_count = 0;
    int planned_occupancy = 0;
    int total_requests = 0;
    int accepted_count = 0;
    int result_count = 0;
    int full_rejects = 0;
    int empty_pops = 0;
    int peak_occupancy = 0;
    int cycle_count = 0;
    int idle_left;
    int style_left;
    int gap_max;
    qwmi_pkg::result_t expected_now;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // The queue is kept in order as one list; a middle insertion lands after
    // the first ceil(n/2) entries.
    task automatic predict_result(input qwmi_pkg::request_t req);
        qwmi_pkg::result_t res;
        int insert_at;
        res = '0;
        res.status = qwmi_pkg::ST_OK;
        case (req.command)
            qwmi_pkg::CMD_APPEND, qwmi_pkg::CMD_INSERT:
            begin
                if (queue_contents.size() >= CAPACITY)
                begin
                    res.status = qwmi_pkg::ST_FULL;
                    full_rejects++;
                end
                else if (req.command == qwmi_pkg::CMD_APPEND)
                begin
                    queue_contents = {queue_contents, req.value};
                end
                else
                begin
                    insert_at = (queue_contents.size() + 1) / 2;
                    queue_contents.insert(insert_at, req.value);
                end
            end
            qwmi_pkg::CMD_POP:
            begin
                if (queue_contents.size() == 0)
                begin
                    res.status = qwmi_pkg::ST_EMPTY;
                    empty_pops++;
                end
                else
                begin
                    res.popped_value = queue_contents[0];
                    queue_contents.delete(0);
                end
            end
            default:
            begin
            end
        endcase
        res.occupancy = qwmi_pkg::occ_t'(queue_contents.size());
        if (queue_contents.size() > peak_occupancy)
        begin
            peak_occupancy = queue_contents.size();
        end
        expected_results = {expected_results, res};
    endtask

    task automatic plan_request(input logic [1:0] cmd, input qwmi_pkg::value_t val);
        qwmi_pkg::request_t req;
        req.command = cmd;
        req.value = val;
        pending_requests = {pending_requests, req};
        planned_count++;
        if (cmd inside {qwmi_pkg::CMD_APPEND, qwmi_pkg::CMD_INSERT}
            && planned_occupancy < CAPACITY)
        begin
            planned_occupancy++;
        end
        else if (cmd == qwmi_pkg::CMD_POP && planned_occupancy > 0)
        begin
            planned_occupancy--;
        end
    endtask

    function automatic qwmi_pkg::value_t random_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            3: return '1;
            default: return qwmi_pkg::value_t'($urandom);
        endcase
    endfunction

    task automatic plan_random(input int push_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 2)
        begin
            plan_request(CMD_NOP, random_value());
            planned_count--;
        end
        else if (pick < 2 + push_pct)
        begin
            plan_request($urandom_range(0, 1) ? qwmi_pkg::CMD_INSERT : qwmi_pkg::CMD_APPEND,
                         random_value());
        end
        else
        begin
            plan_request(qwmi_pkg::CMD_POP, random_value());
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            idle_left = 0;
            style_left = 0;
            gap_max = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_result(request);
                accepted_count++;
            end
            if (!(start && busy))
            begin
                if (idle_left > 0)
                begin
                    start <= 1'b0;
                    idle_left--;
                end
                else if (pending_requests.size() > 0)
                begin
                    start <= 1'b1;
                    request <= pending_requests[0];
                    pending_requests.delete(0);
                    if (style_left == 0)
                    begin
                        style_left = $urandom_range(20, 120);
                        case ($urandom_range(0, 2))
                            0: gap_max = 0;
                            1: gap_max = 2;
                            default: gap_max = 16;
                        endcase
                    end
                    style_left--;
                    idle_left = $urandom_range(0, gap_max);
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count++;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual popped %0d",
                         $time, result.popped_value);
                $display("%0t: actual status %0d occupancy %0d",
                         $time, result.status, result.occupancy);
                error_count++;
            end
            else
            begin
                expected_now = expected_results[0];
                expected_results.delete(0);
                if (result.popped_value !== expected_now.popped_value)
                begin
                    $display("%0t: popped_value mismatch: expected %0d, actual %0d",
                             $time, expected_now.popped_value, result.popped_value);
                    error_count++;
                end
                if (result.status !== expected_now.status)
                begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, expected_now.status, result.status);
                    error_count++;
                end
                if (result.occupancy !== expected_now.occupancy)
                begin
                    $display("%0t: occupancy mismatch: expected %0d, actual %0d",
                             $time, expected_now.occupancy, result.occupancy);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still expected",
                     $time, cycle_count, total_requests - result_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int phase;
        phase = 0;

        plan_request(qwmi_pkg::CMD_POP, '1);
        plan_request(CMD_NOP, VALUE_MAX);
        plan_request(qwmi_pkg::CMD_INSERT, VALUE_MIN);
        plan_request(qwmi_pkg::CMD_APPEND, VALUE_MAX);
        plan_request(qwmi_pkg::CMD_INSERT, '0);
        plan_request(qwmi_pkg::CMD_APPEND, '1);
        plan_request(qwmi_pkg::CMD_INSERT, 32'sd17);
        plan_request(qwmi_pkg::CMD_INSERT, -32'sd5);
        plan_request(qwmi_pkg::CMD_APPEND, 32'sh5555_5555);
        plan_request(CMD_NOP, '0);
        repeat (8) plan_request(qwmi_pkg::CMD_POP, 32'shAAAA_AAAA);
        plan_request(qwmi_pkg::CMD_APPEND, 32'sd1);
        plan_request(qwmi_pkg::CMD_POP, '0);
        plan_request(qwmi_pkg::CMD_POP, '1);

        // Fill to capacity, mix, drain to empty and mix again, so that both
        // the full and the empty boundaries are hit repeatedly.
        while (planned_count < TOTAL_ITEMS)
        begin
            case (phase)
                0:
                begin
                    while (planned_occupancy < CAPACITY) plan_random(85);
                    repeat ($urandom_range(1, 6)) plan_random(100);
                end
                2:
                begin
                    while (planned_occupancy > 0) plan_random(15);
                    repeat ($urandom_range(1, 6)) plan_random(0);
                end
                default:
                begin
                    repeat ($urandom_range(30, 150)) plan_random(50);
                end
            endcase
            phase = (phase + 1) % 4;
        end
        total_requests = pending_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (result_count < total_requests) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Sent %0d requests and checked %0d results; peak occupancy %0d of %0d.",
                 accepted_count, result_count, peak_occupancy, CAPACITY);
        $display("Rejected pushes into a full queue: %0d, pops from an empty queue: %0d.",
                 full_rejects, empty_pops);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== queue_with_middle_insertion.f =====
hdl/qwmi_pkg.sv
hdl/qwmi_cell.sv
hdl/qwmi_ctrl.sv
hdl/queue_with_middle_insertion.sv
tb/tb_top.sv
